/* src/a64enc_pkg.sv */
// Shared types and encoding constants for the AArch64 instruction encoder.
`default_nettype none

package a64enc_pkg;

    typedef enum logic [3:0] {
        OP_ADD_REG = 4'd0,
        OP_ADD_IMM = 4'd1,
        OP_SUB_REG = 4'd2,
        OP_SUB_IMM = 4'd3,
        OP_MOV_REG = 4'd4,
        OP_MOVZ    = 4'd5,
        OP_MOVK    = 4'd6,
        OP_MOVN    = 4'd7,
        OP_B       = 4'd8,
        OP_BL      = 4'd9,
        OP_BCOND   = 4'd10,
        OP_CBZ     = 4'd11,
        OP_CBNZ    = 4'd12,
        OP_RET     = 4'd13,
        OP_BLR     = 4'd14
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_ALIGN = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_IMM   = 2'd3
    } t_err;

    typedef struct packed {
        logic [3:0]         operation;
        logic               wide;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg;
        logic [4:0]         second_reg;
        logic signed [31:0] immediate;
        logic [1:0]         half_shift;
        logic [3:0]         condition;
    } t_req;

    typedef struct packed {
        logic [31:0] machine_word;
        logic [1:0]  error_code;
    } t_rsp;

    // Opcode bases with the size bit (bit 31) cleared where the form has one.
    localparam logic [31:0] BASE_ADD_REG = 32'h0B00_0000;
    localparam logic [31:0] BASE_SUB_REG = 32'h4B00_0000;
    localparam logic [31:0] BASE_ADD_IMM = 32'h1100_0000;
    localparam logic [31:0] BASE_SUB_IMM = 32'h5100_0000;
    localparam logic [31:0] BASE_MOV_REG = 32'h2A00_03E0;
    localparam logic [31:0] BASE_MOVZ    = 32'h5280_0000;
    localparam logic [31:0] BASE_MOVK    = 32'h7280_0000;
    localparam logic [31:0] BASE_MOVN    = 32'h1280_0000;
    localparam logic [31:0] BASE_B       = 32'h1400_0000;
    localparam logic [31:0] BASE_BL      = 32'h9400_0000;
    localparam logic [31:0] BASE_BCOND   = 32'h5400_0000;
    localparam logic [31:0] BASE_CBZ     = 32'h3400_0000;
    localparam logic [31:0] BASE_CBNZ    = 32'h3500_0000;
    localparam logic [31:0] BASE_RET     = 32'hD65F_0000;
    localparam logic [31:0] BASE_BLR     = 32'hD63F_0000;

endpackage

`default_nettype wire

/* src/a64enc_if.sv */
// Valid/ready channel interfaces for encoder requests and results.
`default_nettype none

interface a64enc_req_if
    import a64enc_pkg::*;
;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface a64enc_rsp_if
    import a64enc_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/arm64_instruction_encoder.sv */
// Top level: AArch64 instruction encoder with registered request and result stages.
`default_nettype none

// Encodes one instruction request per cycle into a 32-bit AArch64 machine word and an
// error code (zero word on error). A request is captured in an input register, packed and
// range-checked by one level of logic, and the result is held in an output register; a new
// item is taken every cycle while the result side keeps up. Stalls on the result channel
// propagate back through the two stages.
module arm64_instruction_encoder
    import a64enc_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    a64enc_req_if.sink      i_req,
    a64enc_rsp_if.source    o_rsp
);

    logic        r_s1_valid;
    t_req        r_s1;
    logic        r_out_valid;
    t_rsp        r_out;

    logic        s2_take;
    logic        s1_take;

    logic [31:0] word;
    t_err        err;
    logic [31:0] sf_bit;
    logic [11:0] add_field;
    logic        add_shift;
    logic        br26_ok;
    logic        br19_ok;
    logic        misaligned;
    t_rsp        n_out;

    assign s2_take     = !r_out_valid || o_rsp.ready;
    assign s1_take     = !r_s1_valid || s2_take;
    assign i_req.ready = s1_take;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        sf_bit     = {r_s1.wide, 31'd0};
        misaligned = (r_s1.immediate[1:0] != 2'd0);
        // Word offset fits when all bits above the field match its sign bit.
        br26_ok    = (r_s1.immediate[31:27] == {5{r_s1.immediate[27]}});
        br19_ok    = (r_s1.immediate[31:20] == {12{r_s1.immediate[20]}});
        add_shift  = (r_s1.immediate[30:12] != 19'd0);
        add_field  = add_shift ? r_s1.immediate[23:12] : r_s1.immediate[11:0];
        word       = 32'd0;
        err        = ERR_OK;

        case (r_s1.operation)
            OP_ADD_REG, OP_SUB_REG: begin
                word = ((r_s1.operation == OP_ADD_REG) ? BASE_ADD_REG : BASE_SUB_REG)
                     | sf_bit | {11'd0, r_s1.second_reg, 16'd0}
                     | {22'd0, r_s1.src_reg, 5'd0} | {27'd0, r_s1.dest_reg};
            end
            OP_ADD_IMM, OP_SUB_IMM: begin
                if (r_s1.immediate[31]
                    || (add_shift && (r_s1.immediate[11:0] != 12'd0
                                      || r_s1.immediate[30:24] != 7'd0))) begin
                    err = ERR_IMM;
                end
                word = ((r_s1.operation == OP_ADD_IMM) ? BASE_ADD_IMM : BASE_SUB_IMM)
                     | sf_bit | {9'd0, add_shift, 22'd0} | {10'd0, add_field, 10'd0}
                     | {22'd0, r_s1.src_reg, 5'd0} | {27'd0, r_s1.dest_reg};
            end
            OP_MOV_REG: begin
                word = BASE_MOV_REG | sf_bit | {11'd0, r_s1.second_reg, 16'd0}
                     | {27'd0, r_s1.dest_reg};
            end
            OP_MOVZ, OP_MOVK, OP_MOVN: begin
                // 32-bit forms only allow shifts of 0 and 16.
                if (r_s1.immediate[31:16] != 16'd0 || (!r_s1.wide && r_s1.half_shift[1])) begin
                    err = ERR_IMM;
                end
                word = ((r_s1.operation == OP_MOVZ) ? BASE_MOVZ :
                        (r_s1.operation == OP_MOVK) ? BASE_MOVK : BASE_MOVN)
                     | sf_bit | {9'd0, r_s1.half_shift, 21'd0}
                     | {11'd0, r_s1.immediate[15:0], 5'd0} | {27'd0, r_s1.dest_reg};
            end
            OP_B, OP_BL: begin
                if (misaligned) begin
                    err = ERR_ALIGN;
                end else if (!br26_ok) begin
                    err = ERR_RANGE;
                end
                word = ((r_s1.operation == OP_B) ? BASE_B : BASE_BL)
                     | {6'd0, r_s1.immediate[27:2]};
            end
            OP_BCOND: begin
                if (misaligned) begin
                    err = ERR_ALIGN;
                end else if (!br19_ok) begin
                    err = ERR_RANGE;
                end
                word = BASE_BCOND | {8'd0, r_s1.immediate[20:2], 5'd0}
                     | {28'd0, r_s1.condition};
            end
            OP_CBZ, OP_CBNZ: begin
                if (misaligned) begin
                    err = ERR_ALIGN;
                end else if (!br19_ok) begin
                    err = ERR_RANGE;
                end
                word = ((r_s1.operation == OP_CBZ) ? BASE_CBZ : BASE_CBNZ)
                     | sf_bit | {8'd0, r_s1.immediate[20:2], 5'd0}
                     | {27'd0, r_s1.dest_reg};
            end
            OP_RET: begin
                word = BASE_RET | {22'd0, r_s1.src_reg, 5'd0};
            end
            OP_BLR: begin
                word = BASE_BLR | {22'd0, r_s1.src_reg, 5'd0};
            end
            default: begin
                err = ERR_IMM;
            end
        endcase

        // Drop the word on any fault.
        n_out.machine_word = (err == ERR_OK) ? word : 32'd0;
        n_out.error_code   = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_take) begin
                r_s1_valid <= i_req.valid;
            end
            if (s2_take) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && i_req.valid) begin
            r_s1 <= i_req.data;
        end
        if (s2_take && r_s1_valid) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
